// ===== design/i2cram_pkg.sv =====
`default_nettype none

package i2cram_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF_BIT_TICKS    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT_TICKS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_READ_WAIT_TICKS   = 2'd3;

  localparam logic [6:0] DEV_ADDR_RST    = 7'd116;
  localparam logic [7:0] HALF_TICKS_RST  = 8'd10;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [7:0] READ_WAIT_RST   = 8'd50;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_WRITE,
    KIND_READ
  } kind_e;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] half_ticks;
    logic [7:0] ack_timeout;
    logic [7:0] read_wait;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] reg_idx;
    logic [7:0] wdata;
    logic       sda;
  } entry_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic       aerr;
    logic [7:0] rdata;
  } result_t;

endpackage

`default_nettype wire

// ===== design/i2cram_front.sv =====
`default_nettype none

module i2cram_front import i2cram_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // register_index [7:0], write_data [15:8], sda_in [16]
  input  wire logic [23:0] s_axis_tdata,
  // cmd [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             q_valid_o,
  input  wire logic        q_ready_i,
  output entry_t           q_entry_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  entry_t     new_entry;

  always_comb begin
    case (s_axis_tuser)
      CMD_WRITE: new_entry.kind = KIND_WRITE;
      CMD_READ:  new_entry.kind = KIND_READ;
      default:   new_entry.kind = KIND_TICK;
    endcase
    new_entry.reg_idx = s_axis_tdata[7:0];
    new_entry.wdata   = s_axis_tdata[15:8];
    new_entry.sda     = s_axis_tdata[16];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign pop           = q_valid_o && q_ready_i;
  assign q_entry_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count missed a push");

  a_ptr_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== design/i2cram_back.sv =====
`default_nettype none

module i2cram_back import i2cram_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        q_valid_i,
  output logic             q_ready_o,
  input  wire entry_t      q_entry_i,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // scl_level [0], sda_level [1], sda_drive [2], busy_res [3], ack_error [4],
  // read_data [12:5]
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_A,
    ST_START_B,
    ST_BIT_LOW,
    ST_BIT_HIGH,
    ST_ACK_LOW,
    ST_ACK_HIGH,
    ST_WAIT,
    ST_RD_LOW,
    ST_RD_HIGH,
    ST_NACK_LOW,
    ST_NACK_HIGH,
    ST_STOP_A,
    ST_STOP_B
  } step_e;

  step_e      step_q, step_d;
  logic [7:0] phase_q, phase_d;
  logic [3:0] bitc_q, bitc_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] ackw_q, ackw_d;
  kind_e      kind_q, kind_d;
  logic [7:0] reg_q, reg_d;
  logic [7:0] data_q, data_d;
  logic [1:0] stage_q, stage_d;
  logic       err_q, err_d;
  logic [7:0] recv_q, recv_d;
  logic       out_valid_q;
  result_t    res_q, res_d;

  logic       fire;
  logic [7:0] h_eff, t_eff, w_eff;
  logic [8:0] phase_n, ackw_n;
  logic [3:0] bitc_n;
  logic       over_h, over_w;

  assign q_ready_o = !out_valid_q || m_axis_tready;
  assign fire      = q_valid_i && q_ready_o;

  assign h_eff = (cfg_i.half_ticks == 8'd0) ? 8'd1 : cfg_i.half_ticks;
  assign t_eff = (cfg_i.ack_timeout == 8'd0) ? 8'd1 : cfg_i.ack_timeout;
  assign w_eff = (cfg_i.read_wait == 8'd0) ? 8'd1 : cfg_i.read_wait;

  always_comb begin
    step_d  = step_q;
    phase_d = phase_q;
    bitc_d  = bitc_q;
    shift_d = shift_q;
    ackw_d  = ackw_q;
    kind_d  = kind_q;
    reg_d   = reg_q;
    data_d  = data_q;
    stage_d = stage_q;
    err_d   = err_q;
    recv_d  = recv_q;
    res_d   = '0;

    if (step_q == ST_IDLE && q_entry_i.kind != KIND_TICK) begin
      kind_d  = q_entry_i.kind;
      reg_d   = q_entry_i.reg_idx;
      data_d  = q_entry_i.wdata;
      stage_d = 2'd0;
      err_d   = 1'b0;
      shift_d = {cfg_i.dev_addr, 1'b0};
      phase_d = 8'd0;
      bitc_d  = 4'd0;
      ackw_d  = 8'd0;
      step_d  = ST_START_A;
    end
    res_d.busy = (step_d != ST_IDLE);

    phase_n = {1'b0, phase_d} + 9'd1;
    over_h  = phase_n >= {1'b0, h_eff};
    over_w  = phase_n >= {1'b0, w_eff};
    bitc_n  = bitc_d + 4'd1;
    ackw_n  = {1'b0, ackw_d} + 9'd1;

    case (step_d)
      ST_START_A: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b111;
        if (over_h) begin
          phase_d = 8'd0;
          step_d  = ST_START_B;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_START_B: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b101;
        if (over_h) begin
          phase_d = 8'd0;
          bitc_d  = 4'd0;
          step_d  = ST_BIT_LOW;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_BIT_LOW: begin
        {res_d.scl, res_d.sda, res_d.drv} = {1'b0, shift_d[7], 1'b1};
        if (over_h) begin
          phase_d = 8'd0;
          step_d  = ST_BIT_HIGH;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_BIT_HIGH: begin
        {res_d.scl, res_d.sda, res_d.drv} = {1'b1, shift_d[7], 1'b1};
        if (over_h) begin
          phase_d = 8'd0;
          if (bitc_n >= 4'd8) begin
            bitc_d = 4'd0;
            ackw_d = 8'd0;
            step_d = ST_ACK_LOW;
          end else begin
            bitc_d  = bitc_n;
            shift_d = {shift_d[6:0], 1'b0};
            step_d  = ST_BIT_LOW;
          end
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_ACK_LOW: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b010;
        if (over_h) begin
          phase_d = 8'd0;
          ackw_d  = 8'd0;
          step_d  = ST_ACK_HIGH;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_ACK_HIGH: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b110;
        if (!q_entry_i.sda) begin
          phase_d = 8'd0;
          bitc_d  = 4'd0;
          if (stage_d == 2'd0) begin
            stage_d = 2'd1;
            shift_d = reg_d;
            step_d  = ST_BIT_LOW;
          end else if (stage_d == 2'd1) begin
            stage_d = 2'd2;
            if (kind_d == KIND_WRITE) begin
              shift_d = data_d;
              step_d  = ST_BIT_LOW;
            end else begin
              shift_d = {cfg_i.dev_addr, 1'b1};
              step_d  = ST_START_A;
            end
          end else begin
            if (kind_d == KIND_WRITE) begin
              step_d = ST_STOP_A;
            end else begin
              shift_d = 8'd0;
              step_d  = (cfg_i.read_wait == 8'd0) ? ST_RD_LOW : ST_WAIT;
            end
          end
        end else if (ackw_n >= {1'b0, t_eff}) begin
          ackw_d  = 8'd0;
          err_d   = 1'b1;
          phase_d = 8'd0;
          step_d  = ST_STOP_A;
        end else begin
          ackw_d = ackw_n[7:0];
        end
      end
      ST_WAIT: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b010;
        if (over_w) begin
          phase_d = 8'd0;
          bitc_d  = 4'd0;
          step_d  = ST_RD_LOW;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_RD_LOW: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b010;
        if (over_h) begin
          phase_d = 8'd0;
          step_d  = ST_RD_HIGH;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_RD_HIGH: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b110;
        if (over_h) begin
          phase_d = 8'd0;
          shift_d = {shift_d[6:0], q_entry_i.sda};
          if (bitc_n >= 4'd8) begin
            bitc_d = 4'd0;
            step_d = ST_NACK_LOW;
          end else begin
            bitc_d = bitc_n;
            step_d = ST_RD_LOW;
          end
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_NACK_LOW: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b011;
        if (over_h) begin
          phase_d = 8'd0;
          step_d  = ST_NACK_HIGH;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_NACK_HIGH: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b111;
        if (over_h) begin
          phase_d = 8'd0;
          step_d  = ST_STOP_A;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_STOP_A: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b001;
        if (over_h) begin
          phase_d = 8'd0;
          step_d  = ST_STOP_B;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      ST_STOP_B: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b111;
        if (over_h) begin
          phase_d    = 8'd0;
          res_d.done = 1'b1;
          res_d.aerr = err_d;
          if (kind_d == KIND_READ && !err_d) begin
            recv_d = shift_d;
          end
          step_d = ST_IDLE;
        end else begin
          phase_d = phase_n[7:0];
        end
      end
      default: begin
        {res_d.scl, res_d.sda, res_d.drv} = 3'b111;
        step_d = ST_IDLE;
      end
    endcase

    if (!res_d.drv) begin
      res_d.sda = 1'b1;
    end
    res_d.rdata = recv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      phase_q     <= 8'd0;
      bitc_q      <= 4'd0;
      shift_q     <= 8'd0;
      ackw_q      <= 8'd0;
      kind_q      <= KIND_TICK;
      reg_q       <= 8'd0;
      data_q      <= 8'd0;
      stage_q     <= 2'd0;
      err_q       <= 1'b0;
      recv_q      <= 8'd0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (fire) begin
        step_q  <= step_d;
        phase_q <= phase_d;
        bitc_q  <= bitc_d;
        shift_q <= shift_d;
        ackw_q  <= ackw_d;
        kind_q  <= kind_d;
        reg_q   <= reg_d;
        data_q  <= data_d;
        stage_q <= stage_d;
        err_q   <= err_d;
        recv_q  <= recv_d;
        res_q   <= res_d;
      end
      if (q_ready_o) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.done;
  assign m_axis_tdata  = {3'b000, res_q.rdata, res_q.aerr, res_q.busy,
                          res_q.drv, res_q.sda, res_q.scl};

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done |-> res_q.busy) else $error("done outside a transaction");

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.aerr |-> res_q.done) else $error("ack error without done");

  a_ack_bitc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_ACK_LOW || step_q == ST_ACK_HIGH) |-> bitc_q == 4'd0)
    else $error("bit counter not cleared in ack phase");

  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.busy |-> res_q.scl && res_q.sda && res_q.drv)
    else $error("bus lines not released while idle");

endmodule

`default_nettype wire

// ===== design/i2c_register_access_master_core.sv =====
`default_nettype none

// I2C master for single register writes and reads. Every input word is one
// bus timing tick carrying the sampled SDA level and, while no transaction
// runs, an optional command on tuser (1 write, 2 read, other codes tick only).
// Every input word yields exactly one output word with the SCL/SDA levels,
// the SDA drive enable, busy, ack_error, the last read byte, and tlast on the
// final tick of a transaction. Unless the output stalls, the block takes one
// word per clock cycle: the front end classifies commands into a two-entry
// queue, the sequencer retires one queue entry per cycle into an output
// register, and the only loop is the sequencer state update. Configuration
// registers are written through the cfg port; the user must do so only while
// no transaction is in flight, as the block itself does not enforce this.

module i2c_register_access_master_core import i2cram_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_addr_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // register_index [7:0], write_data [15:8], sda_in [16]
  input  wire logic [23:0]        s_axis_tdata,
  // cmd [1:0]
  input  wire logic [1:0]         s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // scl_level [0], sda_level [1], sda_drive [2], busy_res [3], ack_error [4],
  // read_data [12:5]
  output logic [15:0]             m_axis_tdata,
  output logic                    m_axis_tlast
);

  cfg_t   cfg_q;
  logic   q_valid, q_ready;
  entry_t q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= DEV_ADDR_RST;
      cfg_q.half_ticks  <= HALF_TICKS_RST;
      cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
      cfg_q.read_wait   <= READ_WAIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DEVICE_ADDRESS:    cfg_q.dev_addr    <= cfg_wdata_i[6:0];
        CFG_HALF_BIT_TICKS:    cfg_q.half_ticks  <= cfg_wdata_i;
        CFG_ACK_TIMEOUT_TICKS: cfg_q.ack_timeout <= cfg_wdata_i;
        CFG_READ_WAIT_TICKS:   cfg_q.read_wait   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  i2cram_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_ready_i     (q_ready),
    .q_entry_o     (q_entry)
  );

  i2cram_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_entry_i     (q_entry),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== verif/i2c_register_access_master_core_test.sv =====
`timescale 1ns / 1ps

module i2c_register_access_master_core_test;
  import i2cram_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_COUNT = 450;
  localparam int NO_FAIL = 3;

  typedef enum logic [4:0] {
    SEQ_IDLE,
    SEQ_START_A,
    SEQ_START_B,
    SEQ_BIT_LOW,
    SEQ_BIT_HIGH,
    SEQ_ACK_LOW,
    SEQ_ACK_HIGH,
    SEQ_WAIT,
    SEQ_RD_LOW,
    SEQ_RD_HIGH,
    SEQ_NACK_LOW,
    SEQ_NACK_HIGH,
    SEQ_STOP_A,
    SEQ_STOP_B
  } seq_step_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_idx;
    logic [7:0] wdata;
    logic       sda;
  } tick_t;

  class i2c_bus_scoreboard;
    result_t     levels_q[$];
    int unsigned fail_count;
    int unsigned words_in;
    int unsigned words_seen;
    int unsigned done_seen;
    int unsigned aerr_seen;

    logic [6:0] dev_addr;
    logic [7:0] half_ticks;
    logic [7:0] ack_limit;
    logic [7:0] read_wait;

    seq_step_e  step;
    int         phase;
    int         bitn;
    int         ack_wait;
    int         byte_stage;
    logic [7:0] shifter;
    logic [7:0] rx_byte;
    logic [1:0] lat_cmd;
    logic [7:0] lat_reg;
    logic [7:0] lat_data;
    logic       err_flag;
    logic       scl;
    logic       sda;
    logic       drv;

    function new();
      dev_addr   = DEV_ADDR_RST;
      half_ticks = HALF_TICKS_RST;
      ack_limit  = ACK_TIMEOUT_RST;
      read_wait  = READ_WAIT_RST;
      step       = SEQ_IDLE;
      phase      = 0;
      bitn       = 0;
      ack_wait   = 0;
      byte_stage = 0;
      shifter    = '0;
      rx_byte    = '0;
      lat_cmd    = CMD_TICK;
      lat_reg    = '0;
      lat_data   = '0;
      err_flag   = 1'b0;
      scl        = 1'b1;
      sda        = 1'b1;
      drv        = 1'b1;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_DEVICE_ADDRESS:    dev_addr   = val[6:0];
        CFG_HALF_BIT_TICKS:    half_ticks = val;
        CFG_ACK_TIMEOUT_TICKS: ack_limit  = val;
        CFG_READ_WAIT_TICKS:   read_wait  = val;
        default: ;
      endcase
    endfunction

    function void load_lines(logic s_scl, logic s_sda, logic s_drv);
      scl = s_scl;
      sda = s_sda;
      drv = s_drv;
    endfunction

    function bit phase_done(int len);
      if (len == 0) len = 1;
      phase++;
      if (phase >= len) begin
        phase = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void next_byte();
      phase = 0;
      bitn  = 0;
      if (byte_stage == 0) begin
        byte_stage = 1;
        shifter    = lat_reg;
        step       = SEQ_BIT_LOW;
      end else if (byte_stage == 1) begin
        byte_stage = 2;
        if (lat_cmd == CMD_WRITE) begin
          shifter = lat_data;
          step    = SEQ_BIT_LOW;
        end else begin
          shifter = {dev_addr, 1'b1};
          step    = SEQ_START_A;
        end
      end else if (lat_cmd == CMD_WRITE) begin
        step = SEQ_STOP_A;
      end else begin
        shifter = '0;
        step    = (read_wait == 0) ? SEQ_RD_LOW : SEQ_WAIT;
      end
    endfunction

    function void take_tick(tick_t w);
      result_t r;
      int      lim;
      int      h;
      logic    fin;
      logic    aerr;
      logic    busy;
      h    = half_ticks;
      lim  = (ack_limit == 0) ? 1 : ack_limit;
      fin  = 1'b0;
      aerr = 1'b0;
      words_in++;
      if (step == SEQ_IDLE && (w.cmd == CMD_WRITE || w.cmd == CMD_READ)) begin
        lat_cmd    = w.cmd;
        lat_reg    = w.reg_idx;
        lat_data   = w.wdata;
        byte_stage = 0;
        err_flag   = 1'b0;
        shifter    = {dev_addr, 1'b0};
        phase      = 0;
        bitn       = 0;
        ack_wait   = 0;
        step       = SEQ_START_A;
      end
      busy = (step != SEQ_IDLE);
      case (step)
        SEQ_START_A: begin
          load_lines(1'b1, 1'b1, 1'b1);
          if (phase_done(h)) step = SEQ_START_B;
        end
        SEQ_START_B: begin
          load_lines(1'b1, 1'b0, 1'b1);
          if (phase_done(h)) begin
            bitn = 0;
            step = SEQ_BIT_LOW;
          end
        end
        SEQ_BIT_LOW: begin
          load_lines(1'b0, shifter[7], 1'b1);
          if (phase_done(h)) step = SEQ_BIT_HIGH;
        end
        SEQ_BIT_HIGH: begin
          load_lines(1'b1, shifter[7], 1'b1);
          if (phase_done(h)) begin
            bitn++;
            if (bitn >= 8) begin
              bitn     = 0;
              ack_wait = 0;
              step     = SEQ_ACK_LOW;
            end else begin
              shifter = shifter << 1;
              step    = SEQ_BIT_LOW;
            end
          end
        end
        SEQ_ACK_LOW: begin
          load_lines(1'b0, 1'b1, 1'b0);
          if (phase_done(h)) begin
            ack_wait = 0;
            step     = SEQ_ACK_HIGH;
          end
        end
        SEQ_ACK_HIGH: begin
          load_lines(1'b1, 1'b1, 1'b0);
          if (!w.sda) begin
            next_byte();
          end else begin
            ack_wait++;
            if (ack_wait >= lim) begin
              ack_wait = 0;
              err_flag = 1'b1;
              phase    = 0;
              step     = SEQ_STOP_A;
            end
          end
        end
        SEQ_WAIT: begin
          load_lines(1'b0, 1'b1, 1'b0);
          if (phase_done(read_wait)) begin
            bitn = 0;
            step = SEQ_RD_LOW;
          end
        end
        SEQ_RD_LOW: begin
          load_lines(1'b0, 1'b1, 1'b0);
          if (phase_done(h)) step = SEQ_RD_HIGH;
        end
        SEQ_RD_HIGH: begin
          load_lines(1'b1, 1'b1, 1'b0);
          if (phase_done(h)) begin
            shifter = {shifter[6:0], w.sda};
            bitn++;
            if (bitn >= 8) begin
              bitn = 0;
              step = SEQ_NACK_LOW;
            end else begin
              step = SEQ_RD_LOW;
            end
          end
        end
        SEQ_NACK_LOW: begin
          load_lines(1'b0, 1'b1, 1'b1);
          if (phase_done(h)) step = SEQ_NACK_HIGH;
        end
        SEQ_NACK_HIGH: begin
          load_lines(1'b1, 1'b1, 1'b1);
          if (phase_done(h)) step = SEQ_STOP_A;
        end
        SEQ_STOP_A: begin
          load_lines(1'b0, 1'b0, 1'b1);
          if (phase_done(h)) step = SEQ_STOP_B;
        end
        SEQ_STOP_B: begin
          load_lines(1'b1, 1'b1, 1'b1);
          if (phase_done(h)) begin
            fin  = 1'b1;
            aerr = err_flag;
            if (lat_cmd == CMD_READ && !err_flag) rx_byte = shifter;
            step = SEQ_IDLE;
          end
        end
        default: begin
          step = SEQ_IDLE;
          load_lines(1'b1, 1'b1, 1'b1);
        end
      endcase
      if (fin) done_seen++;
      if (aerr) aerr_seen++;
      r.scl   = scl;
      r.sda   = drv ? sda : 1'b1;
      r.drv   = drv;
      r.busy  = busy;
      r.done  = fin;
      r.aerr  = aerr;
      r.rdata = rx_byte;
      levels_q.push_back(r);
    endfunction

    function void compare_levels(result_t got);
      result_t e;
      words_seen++;
      if (levels_q.size() == 0) begin
        $error("output word %0d arrived with no expected word", words_seen);
        fail_count++;
        return;
      end
      e = levels_q.pop_front();
      if (got.scl !== e.scl) begin
        $error("scl_level expected %0h got %0h", e.scl, got.scl);
        fail_count++;
      end
      if (got.sda !== e.sda) begin
        $error("sda_level expected %0h got %0h", e.sda, got.sda);
        fail_count++;
      end
      if (got.drv !== e.drv) begin
        $error("sda_drive expected %0h got %0h", e.drv, got.drv);
        fail_count++;
      end
      if (got.busy !== e.busy) begin
        $error("busy_res expected %0h got %0h", e.busy, got.busy);
        fail_count++;
      end
      if (got.done !== e.done) begin
        $error("done_res expected %0h got %0h", e.done, got.done);
        fail_count++;
      end
      if (got.aerr !== e.aerr) begin
        $error("ack_error expected %0h got %0h", e.aerr, got.aerr);
        fail_count++;
      end
      if (got.rdata !== e.rdata) begin
        $error("read_data expected %0h got %0h", e.rdata, got.rdata);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr_i = CFG_DEVICE_ADDRESS;
  logic [7:0]         cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;
  logic [1:0]         s_axis_tuser = CMD_TICK;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  logic               m_axis_tlast;

  i2c_bus_scoreboard sb;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_mode = 0;
  int          fail_stage = NO_FAIL;
  int unsigned write_count = 0;
  int unsigned read_count = 0;

  i2c_register_access_master_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** i2c_register_access_master_core: FAILED **");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.scl   = m_axis_tdata[0];
      got.sda   = m_axis_tdata[1];
      got.drv   = m_axis_tdata[2];
      got.busy  = m_axis_tdata[3];
      got.aerr  = m_axis_tdata[4];
      got.rdata = m_axis_tdata[12:5];
      got.done  = m_axis_tlast;
      sb.compare_levels(got);
    end
  end

  task automatic send_word(tick_t w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 16);
      gap = $urandom_range(1, 5);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, w.sda, w.wdata, w.reg_idx};
    s_axis_tuser  <= w.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_tick(w);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.levels_q.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_cfg(logic [6:0] da, logic [7:0] ht, logic [7:0] at, logic [7:0] rw);
    logic [CfgIdxW-1:0] idx_list[4];
    logic [7:0]         vals[4];
    idx_list = '{CFG_DEVICE_ADDRESS, CFG_HALF_BIT_TICKS, CFG_ACK_TIMEOUT_TICKS,
                 CFG_READ_WAIT_TICKS};
    vals = '{{1'b0, da}, ht, at, rw};
    drain();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx_list[i];
      cfg_wdata_i <= vals[i];
      sb.set_reg(idx_list[i], vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic pick_sda();
    if (sb.step == SEQ_ACK_HIGH) begin
      if (sb.byte_stage == fail_stage) return 1'b1;
      if (sb.ack_limit > 3 && $urandom_range(0, 3) == 0) return 1'b1;
      return 1'b0;
    end
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic run_txn(logic [1:0] cmd, logic [7:0] ridx, logic [7:0] data, int fstage);
    tick_t w;
    fail_stage = fstage;
    if (cmd == CMD_WRITE) write_count++;
    else read_count++;
    w.cmd     = cmd;
    w.reg_idx = ridx;
    w.wdata   = data;
    w.sda     = 1'($urandom_range(0, 1));
    send_word(w);
    while (sb.step != SEQ_IDLE) begin
      w.cmd     = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : CMD_TICK;
      w.reg_idx = 8'($urandom_range(0, 255));
      w.wdata   = 8'($urandom_range(0, 255));
      w.sda     = pick_sda();
      send_word(w);
    end
    repeat ($urandom_range(0, 3)) begin
      w.cmd     = $urandom_range(0, 1) ? CMD_TICK : CMD_SPARE;
      w.reg_idx = 8'($urandom_range(0, 255));
      w.wdata   = 8'($urandom_range(0, 255));
      w.sda     = 1'($urandom_range(0, 1));
      send_word(w);
    end
  endtask

  initial begin
    int unsigned base_done;
    sb = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_cfg(DEV_ADDR_RST, 8'd0, 8'd0, 8'd0);
    run_txn(CMD_WRITE, 8'h00, 8'hFF, NO_FAIL);
    run_txn(CMD_READ, 8'hFF, 8'h00, NO_FAIL);
    run_txn(CMD_WRITE, 8'h3C, 8'hC3, 0);

    write_cfg(7'd127, 8'd1, 8'd4, 8'd2);
    run_txn(CMD_READ, 8'h81, 8'h7E, 2);
    run_txn(CMD_WRITE, 8'h7E, 8'h81, 1);

    // hold the sender once until every output word is back
    drain();

    base_done = sb.done_seen;
    while (sb.words_in < ITEM_COUNT) begin
      if (sb.done_seen == base_done || $urandom_range(0, 4) == 0) begin
        write_cfg(7'($urandom_range(0, 127)),
                  ($urandom_range(0, 4) == 0) ? 8'($urandom_range(2, 3))
                                              : 8'($urandom_range(0, 1)),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2))
                                              : 8'($urandom_range(3, 8)),
                  ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 6)));
      end else if ($urandom_range(0, 3) == 0) begin
        drain();
      end
      run_txn($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 2)) : NO_FAIL);
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Ran %0d writes and %0d reads over %0d ticks, %0d output words checked.",
             write_count, read_count, sb.words_in, sb.words_seen);
    $display("Transactions finished: %0d, of them %0d with an ack timeout.",
             sb.done_seen, sb.aerr_seen);
    if (sb.fail_count == 0 && sb.levels_q.size() == 0) begin
      $display("** i2c_register_access_master_core: PASSED **");
    end else begin
      $display("** i2c_register_access_master_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/i2cram_pkg.sv
design/i2cram_front.sv
design/i2cram_back.sv
design/i2c_register_access_master_core.sv
verif/i2c_register_access_master_core_test.sv
